FILE: rtl/brd_pkg.sv
// ----------------------------------------------------------------------------
// brd_pkg
// Shared types, constants and helpers for the binary to radix digit converter.
// ----------------------------------------------------------------------------
package brd_pkg;

  localparam int VALUE_W        = 31;
  localparam int RADIX_W        = 6;
  localparam int DIGIT_W        = 6;
  localparam int CHAR_W         = 7;
  localparam int VALUE_BITS_DEF = 31;
  localparam int MAX_DIGITS_DEF = 32;

  localparam logic [RADIX_W-1:0] RADIX_MIN  = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX  = 6'd36;
  localparam logic [DIGIT_W-1:0] DEC_DIGITS = 6'd10;
  localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0]  CHAR_A     = 7'h41;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [RADIX_W-1:0] radix;
  } in_word_t;

  typedef struct packed {
    logic [CHAR_W-1:0] digit_char;
    logic              last;
  } out_word_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic clear;
    logic shift;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_EMIT
  } state_t;

  function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] d7;
    d7 = {1'b0, d};
    if (d < DEC_DIGITS) begin
      return CHAR_ZERO + d7;
    end else begin
      return CHAR_A + d7 - {1'b0, DEC_DIGITS};
    end
  endfunction

endpackage

FILE: rtl/binary_to_radix_digits.sv
// ----------------------------------------------------------------------------
// binary_to_radix_digits
// Converts a binary value to ASCII digits in radix 2..36, most significant
// first, with the final digit flagged.
// ----------------------------------------------------------------------------
//  channel | ports                          | word
//  --------+--------------------------------+-------------------------------
//  input   | in_valid, in_stall, in_word    | value[30:0], radix[5:0]
//  output  | out_valid, out_stall, out_word | digit_char[6:0], last
//
//  The value is shifted MSB first into a skewed chain of MAX_DIGITS digit
//  cells; the conversion time is set by VALUE_BITS and the carry skew along
//  the chain. The chain then shifts toward the top cell, skipping leading
//  zeros until it finds the leading digit, then shifts once per digit sent.
//  in_stall is high from acceptance until the last digit is loaded into the
//  output register; a stalled output word holds. Reset is synchronous.
// ----------------------------------------------------------------------------
module binary_to_radix_digits #(
  parameter int VALUE_BITS = brd_pkg::VALUE_BITS_DEF,
  parameter int MAX_DIGITS = brd_pkg::MAX_DIGITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  brd_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output brd_pkg::out_word_t out_word
);
  import brd_pkg::*;

  localparam int CYC_W = $clog2(VALUE_BITS + MAX_DIGITS);
  localparam int REM_W = $clog2(MAX_DIGITS + 1);
  localparam logic [CYC_W-1:0] CYC_END  = CYC_W'(VALUE_BITS + MAX_DIGITS - 2);
  localparam logic [CYC_W-1:0] CYC_BITS = CYC_W'(VALUE_BITS);
  localparam logic [REM_W-1:0] REM_FULL = REM_W'(MAX_DIGITS);
  localparam logic [REM_W-1:0] REM_ONE  = REM_W'(1);

  state_t              state_r, state_nxt;
  logic [VALUE_BITS-1:0] val_r;
  logic [VALUE_BITS-1:0] val_in;
  logic [RADIX_W-1:0]  rad_r;
  logic [RADIX_W-1:0]  rad_in;
  logic [CYC_W-1:0]    cyc_r;
  logic [REM_W-1:0]    rem_r;
  logic                ovf_r;
  logic                out_valid_r;
  out_word_t           out_word_r;

  logic                in_fire;
  logic                out_free;
  logic                emit_now;
  logic                act0;
  logic                top_zero;
  logic                ovf;
  cell_ctl_t           ctl;

  logic               act_c   [MAX_DIGITS+1];
  logic               carry_c [MAX_DIGITS+1];
  logic [DIGIT_W-1:0] dig_c   [MAX_DIGITS+1];

  // value field widened or narrowed to VALUE_BITS
  generate
    if (VALUE_BITS <= VALUE_W) begin : g_trunc
      assign val_in = in_word.value[VALUE_BITS-1:0];
    end else begin : g_ext
      assign val_in = {{(VALUE_BITS - VALUE_W){1'b0}}, in_word.value};
    end
  endgenerate

  always_comb begin
    if (in_word.radix < RADIX_MIN) begin
      rad_in = RADIX_MIN;
    end else if (in_word.radix > RADIX_MAX) begin
      rad_in = RADIX_MAX;
    end else begin
      rad_in = in_word.radix;
    end
  end

  assign in_fire  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign top_zero = (dig_c[MAX_DIGITS] == '0);
  // a carry out of the top cell means more digits than cells: send them all
  assign ovf      = ovf_r || carry_c[MAX_DIGITS];

  // cell chain: cell 0 takes the value bits, cell i feeds cell i+1
  assign act_c[0]   = act0;
  assign carry_c[0] = val_r[VALUE_BITS-1];
  assign dig_c[0]   = '0;

  generate
    for (genvar i = 0; i < MAX_DIGITS; i++) begin : g_cell
      brd_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .radix     (rad_r),
        .act_in    (act_c[i]),
        .carry_in  (carry_c[i]),
        .digit_in  (dig_c[i]),
        .act_out   (act_c[i+1]),
        .carry_out (carry_c[i+1]),
        .digit     (dig_c[i+1])
      );
    end
  endgenerate

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) state_nxt = ST_CONV;
      end
      ST_CONV: begin
        if (cyc_r == CYC_END) state_nxt = ST_SKIP;
      end
      ST_SKIP: begin
        if (!top_zero || ovf || rem_r == REM_ONE) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free && rem_r == REM_ONE) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall  = 1'b1;
    ctl.clear = 1'b0;
    ctl.shift = 1'b0;
    act0      = 1'b0;
    emit_now  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall  = 1'b0;
        ctl.clear = in_valid;
      end
      ST_CONV: begin
        act0 = (cyc_r < CYC_BITS);
      end
      ST_SKIP: begin
        ctl.shift = top_zero && !ovf && (rem_r != REM_ONE);
      end
      ST_EMIT: begin
        emit_now  = out_free;
        ctl.shift = out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cyc_r       <= '0;
      rem_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_fire) begin
        cyc_r <= '0;
      end else if (state_r == ST_CONV) begin
        cyc_r <= cyc_r + CYC_W'(1);
      end
      if (in_fire) begin
        rem_r <= REM_FULL;
      end else if (ctl.shift) begin
        rem_r <= rem_r - REM_ONE;
      end
      if (in_fire) begin
        ovf_r <= 1'b0;
      end else begin
        ovf_r <= ovf;
      end
      if (emit_now) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      val_r <= val_in;
      rad_r <= rad_in;
    end else if (state_r == ST_CONV) begin
      val_r <= {val_r[VALUE_BITS-2:0], 1'b0};
    end
    if (emit_now) begin
      out_word_r.digit_char <= digit_to_char(dig_c[MAX_DIGITS]);
      out_word_r.last       <= (rem_r == REM_ONE);
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

FILE: rtl/brd_cell.sv
// ----------------------------------------------------------------------------
// brd_cell
// One radix digit of the conversion chain: doubles its digit and adds the
// incoming carry modulo the radix, handing the carry up in the next cycle.
// ----------------------------------------------------------------------------
module brd_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  brd_pkg::cell_ctl_t         ctl,
  input  logic [brd_pkg::RADIX_W-1:0] radix,
  input  logic                       act_in,
  input  logic                       carry_in,
  input  logic [brd_pkg::DIGIT_W-1:0] digit_in,
  output logic                       act_out,
  output logic                       carry_out,
  output logic [brd_pkg::DIGIT_W-1:0] digit
);
  import brd_pkg::*;

  logic               act_r;
  logic               carry_r;
  logic [DIGIT_W-1:0] digit_r;
  logic [DIGIT_W:0]   dbl;
  logic [DIGIT_W:0]   red;
  logic               ge;

  // digit < radix, so 2*digit + 1 < 2*radix: one compare and subtract
  always_comb begin
    dbl = {digit_r, carry_in};
    ge  = (dbl >= {1'b0, radix});
    red = ge ? (dbl - {1'b0, radix}) : dbl;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r   <= 1'b0;
      carry_r <= 1'b0;
    end else if (ctl.clear) begin
      act_r   <= 1'b0;
      carry_r <= 1'b0;
    end else begin
      act_r   <= act_in;
      carry_r <= act_in & ge;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      digit_r <= '0;
    end else if (ctl.shift) begin
      digit_r <= digit_in;
    end else if (act_in) begin
      digit_r <= red[DIGIT_W-1:0];
    end
  end

  assign act_out   = act_r;
  assign carry_out = carry_r;
  assign digit     = digit_r;

endmodule

FILE: tb/sv/binary_to_radix_digits_tb.sv
// ----------------------------------------------------------------------------
// binary_to_radix_digits_tb
// Feeds value/radix words into the radix digit converter and checks every
// ASCII digit word that comes back, in order, against a local digit model.
// A short table of edge cases runs first, then random words under several
// sender-idle and receiver-stall mixes.
// ----------------------------------------------------------------------------
module binary_to_radix_digits_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import brd_pkg::*;

  localparam int NUM_DIRECTED = 25;
  localparam int RANDOM_PER_PHASE = 26;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;

  out_word_t pending_digits[$];
  int        mismatches = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;

  // edge cases; a non-empty text is the exact digit string expected
  logic [VALUE_W-1:0] dir_value [NUM_DIRECTED] = '{
    31'd0, 31'd0, 31'd0, 31'd1,
    31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
    31'd35, 31'd36, 31'd9, 31'd10,
    31'd5, 31'd6, 31'd35, 31'd36, 31'd0,
    31'd1073741824, 31'h7FFF_FFFF, 31'd123456789, 31'h7FFF_FFFF, 31'd2147483646,
    31'd1295, 31'd255
  };
  logic [RADIX_W-1:0] dir_radix [NUM_DIRECTED] = '{
    6'd10, 6'd2, 6'd36, 6'd2,
    6'd2, 6'd8, 6'd10, 6'd16, 6'd36,
    6'd36, 6'd36, 6'd10, 6'd11,
    6'd0, 6'd1, 6'd63, 6'd37, 6'd63,
    6'd2, 6'd3, 6'd7, 6'd35, 6'd62,
    6'd36, 6'd16
  };
  string dir_text [NUM_DIRECTED] = '{
    "0", "0", "0", "1",
    "1111111111111111111111111111111", "17777777777", "2147483647", "7FFFFFFF",
    "ZIK0ZJ",
    "Z", "10", "9", "A",
    "101", "110", "Z", "10", "0",
    "", "", "", "", "",
    "ZZ", "FF"
  };

  binary_to_radix_digits DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // repeated division, remainders replayed most significant first
  function automatic void predict_digits(input in_word_t w);
    logic [VALUE_W-1:0] rest;
    logic [RADIX_W-1:0] base;
    logic [DIGIT_W-1:0] rems [MAX_DIGITS_DEF];
    int                 n;
    out_word_t          o;
    rest = w.value;
    base = w.radix;
    if (base < RADIX_MIN) begin
      base = RADIX_MIN;
    end else if (base > RADIX_MAX) begin
      base = RADIX_MAX;
    end
    n = 0;
    if (rest == '0) begin
      rems[0] = '0;
      n = 1;
    end else begin
      while (rest != '0 && n < MAX_DIGITS_DEF) begin
        rems[n] = DIGIT_W'(rest % base);
        rest = rest / base;
        n++;
      end
    end
    for (int k = n - 1; k >= 0; k--) begin
      if (rems[k] < 6'd10) begin
        o.digit_char = CHAR_W'(8'h30 + rems[k]);
      end else begin
        o.digit_char = CHAR_W'(8'h41 + rems[k] - 8'd10);
      end
      o.last = (k == 0);
      pending_digits.push_back(o);
    end
  endfunction

  function automatic void expect_text(input string text);
    out_word_t o;
    for (int i = 0; i < text.len(); i++) begin
      o.digit_char = CHAR_W'(text[i]);
      o.last = (i == text.len() - 1);
      pending_digits.push_back(o);
    end
  endfunction

  function automatic in_word_t random_word();
    in_word_t w;
    case ($urandom_range(0, 3))
      0: w.value = VALUE_W'($urandom);
      1: w.value = VALUE_W'($urandom_range(0, 100));
      2: w.value = VALUE_W'($urandom) >> $urandom_range(0, VALUE_W - 1);
      default: w.value = {VALUE_W{1'b1}} >> $urandom_range(0, VALUE_W - 1);
    endcase
    // mostly legal radices, now and then any 6-bit code
    if ($urandom_range(0, 7) == 0) begin
      w.radix = RADIX_W'($urandom);
    end else begin
      w.radix = RADIX_W'($urandom_range(2, 36));
    end
    return w;
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t ns: %s", $time, what);
    mismatches++;
  endtask

  // returns once the word is accepted; in_valid stays high for the caller
  task automatic send_word(input in_word_t w, input string text);
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (in_stall);
    if (text.len() != 0) begin
      expect_text(text);
    end else begin
      predict_digits(w);
    end
  endtask

  task automatic wait_drained();
    while (pending_digits.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_digits.size() == 0) begin
        report_mismatch($sformatf("unexpected word char=%02h last=%0b",
                                  out_word.digit_char, out_word.last));
      end else begin
        want = pending_digits.pop_front();
        if (out_word.digit_char !== want.digit_char)
          report_mismatch($sformatf("digit_char %02h, expected %02h",
                                    out_word.digit_char, want.digit_char));
        if (out_word.last !== want.last)
          report_mismatch($sformatf("last %0b, expected %0b", out_word.last, want.last));
      end
    end
    out_stall <= (recv_stall_pct != 0 && $urandom_range(0, 99) < recv_stall_pct);
  end

  initial begin
    in_word_t w;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < NUM_DIRECTED; i++) begin
      w.value = dir_value[i];
      w.radix = dir_radix[i];
      send_word(w, dir_text[i]);
    end
    // hold off the sender until the block has emptied out
    in_valid <= 1'b0;
    wait_drained();

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
        default: begin send_idle_pct = 6; recv_stall_pct = 6; end
      endcase
      repeat (RANDOM_PER_PHASE) send_word(random_word(), "");
    end
    in_valid <= 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    wait_drained();
    // catch stray words past the last expected one
    repeat (100) @(posedge clk);

    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("timeout with %0d words outstanding", pending_digits.size());
    $display("status: fail");
    $finish;
  end

endmodule
